/* rtl/core/sbus_pkg.sv */
// Shared constants, codes and types for the SBUS frame decoder.
// No dependencies; imported by sbus_frame_decoder and sbus_unpacker.
package sbus_pkg;

  localparam int FRAME_BYTES      = 25;
  localparam int STORE_DEPTH      = FRAME_BYTES - 1;   // bytes after the header
  localparam int STORE_AW         = $clog2(STORE_DEPTH);
  localparam int FLAG_POS         = FRAME_BYTES - 3;
  localparam int END_POS          = FRAME_BYTES - 2;
  localparam int NUM_CHANNELS_DEF = 16;
  localparam int CH_BITS          = 11;
  localparam int IDX_BITS         = 4;
  localparam int BITPOS_W         = 8;                 // up to 11 * 16

  localparam logic [7:0]         HEADER_BYTE    = 8'h0F;
  localparam logic [7:0]         END_BYTE       = 8'h00;
  localparam logic [CH_BITS-1:0] DISABLED_VALUE = 11'd1023;
  localparam int                 FLAG_LOST_BIT  = 2;
  localparam int                 FLAG_FS_BIT    = 3;

  typedef enum logic [1:0] {
    LINK_OK       = 2'd0,
    LINK_LOST     = 2'd1,
    LINK_FAILSAFE = 2'd2
  } link_t;

  // request from the frame sequencer to the unpacker
  typedef struct packed {
    logic                start;
    logic [BITPOS_W-1:0] bit_pos;
  } unp_req_t;

  // answer from the unpacker
  typedef struct packed {
    logic               done;
    logic [CH_BITS-1:0] value;
  } unp_rsp_t;

endpackage

/* rtl/core/sbus_frame_decoder.sv */
// SBUS frame decoder top level: byte intake, frame store and result sequencer.
// Depends on sbus_pkg, sbus_ram and sbus_unpacker.
//
// Received bytes are taken one per cycle while the block hunts for the 0x0F
// header and while it collects the 24 bytes that follow; header hunting,
// the flag byte and the end-byte check cost nothing extra. Once a frame with
// a 0x00 end byte is complete the block stops taking bytes and emits
// NUM_CHANNELS channel beats in ascending order. Each channel needs three
// reads through the single read port of the frame RAM plus one shift; no
// byte is taken until the last channel beat has been accepted, so output
// stalls hold off intake too. A frame with a bad end byte is dropped silently
// and hunting resumes on the next byte. When all_channels is 0, channel
// indices 8 and up carry 1023. The store needs no clearing after reset.
module sbus_frame_decoder
  import sbus_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          rx_byte,
  input  logic                in_valid,
  output logic                in_ready,
  output logic [IDX_BITS-1:0] channel_index,
  output logic [CH_BITS-1:0]  channel_value,
  output logic [1:0]          link_status,
  output logic                last_of_frame,
  output logic                out_valid,
  input  logic                out_ready,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  typedef enum logic [2:0] {
    ST_RECV  = 3'b001,
    ST_FETCH = 3'b010,
    ST_OUT   = 3'b100
  } state_t;

  localparam logic [IDX_BITS-1:0] LAST_CH = IDX_BITS'(NUM_CHANNELS - 1);

  state_t              state, state_next;
  logic                all_channels;
  logic                collecting;
  logic [STORE_AW-1:0] byte_count;
  link_t               status;
  logic [IDX_BITS-1:0] ch;
  logic [BITPOS_W-1:0] bit_pos;
  logic                in_beat, out_beat, good_end, next_ch;
  logic                store_we;
  logic [STORE_AW-1:0] raddr;
  logic [7:0]          rdata;
  unp_req_t            req;
  unp_rsp_t            rsp;

  assign in_ready  = (state == ST_RECV);
  assign out_valid = (state == ST_OUT);
  assign in_beat   = in_valid && in_ready;
  assign out_beat  = out_valid && out_ready;
  assign store_we  = in_beat && collecting;
  assign good_end  = store_we && (byte_count == STORE_AW'(END_POS)) && (rx_byte == END_BYTE);
  assign next_ch   = out_beat && (ch != LAST_CH);

  assign req.start   = good_end || next_ch;
  assign req.bit_pos = good_end ? '0 : bit_pos + BITPOS_W'(CH_BITS);

  assign channel_index = ch;
  assign link_status   = status;
  assign last_of_frame = (ch == LAST_CH);

  always_comb begin
    state_next = state;
    case (state)
      ST_RECV:  if (good_end) state_next = ST_FETCH;
      ST_FETCH: if (rsp.done) state_next = ST_OUT;
      ST_OUT: begin
        if (out_beat) state_next = last_of_frame ? ST_RECV : ST_FETCH;
      end
      default:  state_next = ST_RECV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_RECV;
      all_channels <= 1'b1;
      collecting   <= 1'b0;
      byte_count   <= '0;
      ch           <= '0;
      bit_pos      <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        all_channels <= cfg_wdata;
      end
      if (in_beat) begin
        if (!collecting) begin
          if (rx_byte == HEADER_BYTE) begin
            collecting <= 1'b1;
            byte_count <= '0;
          end
        end else if (byte_count == STORE_AW'(END_POS)) begin
          collecting <= 1'b0;
          byte_count <= '0;
        end else begin
          byte_count <= byte_count + 1'b1;
        end
      end
      if (req.start) begin
        bit_pos <= req.bit_pos;
        ch      <= good_end ? '0 : ch + 1'b1;
      end
    end
  end

  // flag byte decoded as it passes; failsafe takes priority over lost
  always_ff @(posedge clk) begin
    if (store_we && byte_count == STORE_AW'(FLAG_POS)) begin
      if (rx_byte[FLAG_FS_BIT]) begin
        status <= LINK_FAILSAFE;
      end else if (rx_byte[FLAG_LOST_BIT]) begin
        status <= LINK_LOST;
      end else begin
        status <= LINK_OK;
      end
    end
    if (state == ST_FETCH && rsp.done) begin
      channel_value <= (ch >= IDX_BITS'(8) && !all_channels) ? DISABLED_VALUE : rsp.value;
    end
  end

  sbus_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (byte_count),
    .wdata (rx_byte),
    .raddr (raddr),
    .rdata (rdata)
  );

  sbus_unpacker u_unpack (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .raddr (raddr),
    .rdata (rdata),
    .rsp   (rsp)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("byte intake open while a channel beat is pending");

  a_refetch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_of_frame) |=> !out_valid)
    else $error("next channel shown without a fetch");

  a_done_in_fetch: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> (state == ST_FETCH))
    else $error("unpacker finished outside a fetch");

  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_of_frame) |=> in_ready)
    else $error("intake not reopened after the last channel");

endmodule

/* rtl/core/sbus_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbus_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/sbus_unpacker.sv */
// Channel unpacker: reads three frame bytes through the RAM read port and
// extracts one 11-bit LSB-first field with a shared barrel shift. Uses sbus_pkg.
module sbus_unpacker
  import sbus_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  unp_req_t            req,
  output logic [STORE_AW-1:0] raddr,
  input  logic [7:0]          rdata,
  output unp_rsp_t            rsp
);

  typedef enum logic [1:0] {
    U_IDLE  = 2'b01,
    U_FETCH = 2'b10
  } ustate_t;

  ustate_t             state, state_next;
  logic [1:0]          step;
  logic [STORE_AW-1:0] at;
  logic [2:0]          sh;
  logic [15:0]         win;
  logic [23:0]         word;

  assign raddr = at + STORE_AW'(step);
  assign word  = {rdata, win};

  always_comb begin
    state_next = state;
    case (state)
      U_IDLE:  if (req.start) state_next = U_FETCH;
      U_FETCH: if (step == 2'd3) state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= U_IDLE;
      step     <= '0;
      rsp.done <= 1'b0;
    end else begin
      state    <= state_next;
      rsp.done <= (state == U_FETCH) && (step == 2'd3);
      if (state == U_IDLE) begin
        step <= '0;
      end else begin
        step <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == U_IDLE && req.start) begin
      at <= req.bit_pos[BITPOS_W-1:3];
      sh <= req.bit_pos[2:0];
    end
    // read data is registered, so it arrives in the cycle after its address
    if (state == U_FETCH) begin
      case (step)
        2'd1:    win[7:0]  <= rdata;
        2'd2:    win[15:8] <= rdata;
        2'd3:    rsp.value <= CH_BITS'(word >> sh);
        default: ;
      endcase
    end
  end

endmodule
